### rtl/core/uosc_pkg.sv
// uosc_pkg: shared types and constants of the ultimate oscillator filter.
// Used by the controller, the datapath and the top level. Depends on nothing.
package uosc_pkg;

  localparam int COEF_W    = 32;
  localparam int HIST_W    = 48;
  localparam int ACC_W     = 54;
  localparam int SIG_W     = 28;
  localparam int OSC_W     = 24;
  localparam int SUM_W     = 64;
  localparam int REG_IDX_W = 3;
  localparam int NUM_REGS  = 6;
  localparam int CNT_W     = 6;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LONG_C1  = 3'd0,
    REG_LONG_C2  = 3'd1,
    REG_LONG_C3  = 3'd2,
    REG_SHORT_C1 = 3'd3,
    REG_SHORT_C2 = 3'd4,
    REG_SHORT_C3 = 3'd5
  } reg_idx_t;

  localparam logic signed [COEF_W-1:0] COEF_RESET [NUM_REGS] = '{
    32'sd949112610, 32'sd1883772656, -32'sd838925225,
    32'sd839075549, 32'sd1627051723, -32'sd655497909
  };

  // filter terms, in the same order as the coefficient registers
  typedef enum logic [2:0] {
    T_LONG_IN   = 3'd0,
    T_LONG_FB1  = 3'd1,
    T_LONG_FB2  = 3'd2,
    T_SHORT_IN  = 3'd3,
    T_SHORT_FB1 = 3'd4,
    T_SHORT_FB2 = 3'd5
  } term_t;

  typedef enum logic [1:0] {
    MUL_COEF_LO = 2'd0,
    MUL_COEF_HI = 2'd1,
    MUL_OLD     = 2'd2,
    MUL_NEW     = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic     clr_step;
    logic     load;
    logic     mul;
    mul_sel_t mul_sel;
    term_t    term;
    logic     cons;
    logic     ring_rd;
    logic     sq_old;
    logic     sq_new;
    logic     sum_add;
    logic     zchk;
    logic     norm_step;
    logic     div_load1;
    logic     rdiv_step;
    logic     div_step;
    logic     sqrt_load;
    logic     sqrt_step;
    logic     div_load2;
    logic     fin;
  } cmd_t;

  typedef struct packed {
    logic ptr_last;
    logic norm_done;
    logic sum_zero;
    logic out_free;
  } stat_t;

endpackage

### rtl/core/uosc_ram.sv
// uosc_ram: generic single-clock ram, one write and one registered read port.
// No dependencies.
module uosc_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 100,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/uosc_dp.sv
// uosc_dp: datapath of the oscillator: coefficient registers, shared multiplier,
// filter state, signal ring, sum of squares, divider and square root.
// Depends on uosc_pkg and uosc_ram.
module uosc_dp import uosc_pkg::*; #(
  parameter int RMS_WINDOW  = 100,
  parameter int SAMPLE_BITS = 32,
  localparam int AW = (RMS_WINDOW > 1) ? $clog2(RMS_WINDOW) : 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [REG_IDX_W-1:0]    cfg_index,
  input  logic [COEF_W-1:0]       cfg_data,
  input  logic [31:0]             sample,
  input  cmd_t                    cmd,
  output stat_t                   stat,
  output logic signed [OSC_W-1:0] oscillator,
  output logic                    rms_zero,
  output logic                    out_valid,
  input  logic                    out_stall
);

  localparam logic [63:0] OSC_POS_MAX = 64'((64'd1 << (OSC_W - 1)) - 64'd1);
  localparam logic [63:0] OSC_NEG_MAG = 64'(64'd1 << (OSC_W - 1));
  // ceil(2^32 / window): exact quotient of any 24-bit value while the window fits 8 bits
  localparam logic [31:0] RECIP =
    32'(((64'd1 << 32) + 64'(RMS_WINDOW) - 64'd1) / 64'(RMS_WINDOW));

  logic signed [COEF_W-1:0] coef [NUM_REGS];
  logic signed [SAMPLE_BITS-1:0] x1, x2;
  logic signed [HIST_W-1:0] diffq8, lh0, lh1, sh0, sh1, lp, sp;
  logic signed [ACC_W-1:0] acc;
  logic [63:0] prod;
  logic [33:0] tlo;
  logic signed [SIG_W-1:0] sig;
  logic [SUM_W-1:0] ssum, nrm;
  logic [4:0] tsh;
  logic zflag;
  logic [AW-1:0] ptr;
  logic [63:0] dvd;
  logic [32:0] dvs, rem;
  logic [63:0] sv;
  logic [31:0] root;
  logic [32:0] srem;

  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [HIST_W-1:0] diff, op_a, fval;
  logic signed [COEF_W-1:0] op_c;
  logic [HIST_W-1:0] am;
  logic [COEF_W-1:0] cm;
  logic neg;
  logic [31:0] ma, mb;
  logic [49:0] tmag;
  logic signed [ACC_W-1:0] tsgn, acc_sum;
  logic signed [HIST_W:0] sdiff;
  logic signed [SIG_W-1:0] sig_next;
  logic signed [SIG_W-1:0] old;
  logic [SIG_W-1:0] smag, omag;
  logic [63:0] num;
  logic [31:0] rr;
  logic [33:0] dtr;
  logic dge;
  logic [34:0] str, trial;
  logic [OSC_W-1:0] osc_next;
  logic ram_we;
  logic [SIG_W-1:0] ram_wdata;
  logic [23:0] rv, rrem;
  logic [55:0] rprod;
  logic [15:0] rq;

  function automatic logic signed [HIST_W-1:0] sat_hist(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi, lo;
    hi = ACC_W'({1'b0, {(HIST_W-1){1'b1}}});
    lo = ~hi;
    if (v > hi) begin
      return hi[HIST_W-1:0];
    end else if (v < lo) begin
      return lo[HIST_W-1:0];
    end
    return v[HIST_W-1:0];
  endfunction

  function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [HIST_W:0] v);
    logic signed [HIST_W:0] hi, lo;
    hi = (HIST_W+1)'({1'b0, {(SIG_W-1){1'b1}}});
    lo = ~hi;
    if (v > hi) begin
      return hi[SIG_W-1:0];
    end else if (v < lo) begin
      return lo[SIG_W-1:0];
    end
    return v[SIG_W-1:0];
  endfunction

  // second difference of the samples, in Q.8
  assign x    = signed'(sample[SAMPLE_BITS-1:0]);
  assign diff = HIST_W'(x) - (HIST_W'(x1) <<< 1) + HIST_W'(x2);

  always_comb begin
    case (cmd.term)
      T_LONG_IN, T_SHORT_IN: op_a = diffq8;
      T_LONG_FB1:            op_a = lh0;
      T_LONG_FB2:            op_a = lh1;
      T_SHORT_FB1:           op_a = sh0;
      default:               op_a = sh1;
    endcase
  end

  assign op_c = coef[cmd.term];
  assign am   = op_a[HIST_W-1] ? HIST_W'(-op_a) : HIST_W'(op_a);
  assign cm   = op_c[COEF_W-1] ? COEF_W'(-op_c) : COEF_W'(op_c);
  assign neg  = op_a[HIST_W-1] ^ op_c[COEF_W-1];
  assign smag = sig[SIG_W-1] ? SIG_W'(-sig) : SIG_W'(sig);
  assign omag = old[SIG_W-1] ? SIG_W'(-old) : SIG_W'(old);

  always_comb begin
    case (cmd.mul_sel)
      MUL_COEF_LO: begin
        ma = am[31:0];
        mb = cm;
      end
      MUL_COEF_HI: begin
        ma = 32'(am[HIST_W-1:32]);
        mb = cm;
      end
      MUL_OLD: begin
        ma = 32'(omag);
        mb = 32'(omag);
      end
      default: begin
        ma = 32'(smag);
        mb = 32'(smag);
      end
    endcase
  end

  // high partial product joins the rounded low one
  assign tmag    = {prod[47:0], 2'b00} + 50'(tlo);
  assign tsgn    = neg ? -ACC_W'(signed'({1'b0, tmag})) : ACC_W'(signed'({1'b0, tmag}));
  assign acc_sum = acc + tsgn;
  assign fval    = sat_hist(acc_sum);

  assign sdiff    = (HIST_W+1)'(lp) - (HIST_W+1)'(sp);
  assign sig_next = sat_sig(sdiff);

  assign num   = 64'(smag) << (7'd16 + 7'(tsh));
  assign rr    = (root == 32'd0) ? 32'd1 : root;
  assign dtr   = {rem, dvd[63]};
  assign dge   = dtr >= {1'b0, dvs};
  assign str   = {srem, sv[63:62]};
  assign trial = {1'b0, root, 2'b01};

  // divide by the window, 16 bits a step: remainder and next digit times the reciprocal
  assign rv    = {rem[7:0], dvd[63:48]};
  assign rprod = 56'(rv) * 56'(RECIP);
  assign rq    = 16'(rprod >> 32);
  assign rrem  = rv - 24'(rq) * 24'(RMS_WINDOW);

  always_comb begin
    if (zflag) begin
      osc_next = '0;
    end else if (sig[SIG_W-1]) begin
      osc_next = (dvd >= OSC_NEG_MAG) ? OSC_NEG_MAG[OSC_W-1:0] : OSC_W'(-dvd[OSC_W-1:0]);
    end else begin
      osc_next = (dvd > OSC_POS_MAX) ? OSC_POS_MAX[OSC_W-1:0] : dvd[OSC_W-1:0];
    end
  end

  assign ram_we    = cmd.clr_step | cmd.sq_old;
  assign ram_wdata = cmd.clr_step ? '0 : sig;

  uosc_ram #(.WIDTH(SIG_W), .DEPTH(RMS_WINDOW)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr),
    .wdata (ram_wdata),
    .re    (cmd.ring_rd),
    .raddr (ptr),
    .rdata (old)
  );

  assign stat.ptr_last  = ptr == AW'(RMS_WINDOW - 1);
  assign stat.norm_done = (nrm[63:62] != 2'b00) || (tsh == 5'd31);
  assign stat.sum_zero  = ssum == '0;
  assign stat.out_free  = !out_valid || !out_stall;

  // configuration and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        coef[i] <= COEF_RESET[i];
      end
      x1        <= '0;
      x2        <= '0;
      lh0       <= '0;
      lh1       <= '0;
      sh0       <= '0;
      sh1       <= '0;
      acc       <= '0;
      ptr       <= '0;
      ssum      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index < REG_IDX_W'(NUM_REGS))) begin
        coef[cfg_index] <= cfg_data;
      end
      if (cmd.load) begin
        x1 <= x;
        x2 <= x1;
      end
      if (cmd.cons && cmd.mul_sel == MUL_COEF_HI) begin
        if (cmd.term == T_LONG_FB2) begin
          lh0 <= fval;
          lh1 <= lh0;
          acc <= '0;
        end else if (cmd.term == T_SHORT_FB2) begin
          sh0 <= fval;
          sh1 <= sh0;
          acc <= '0;
        end else begin
          acc <= acc_sum;
        end
      end
      if (cmd.clr_step || cmd.sq_old) begin
        ptr <= stat.ptr_last ? '0 : ptr + AW'(1);
      end
      if (cmd.sq_new) begin
        ssum <= ssum - prod;
      end else if (cmd.sum_add) begin
        ssum <= ssum + prod;
      end
      if (cmd.fin) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      diffq8 <= diff <<< 8;
    end
    if (cmd.mul) begin
      prod <= ma * mb;
    end
    if (cmd.cons && cmd.mul_sel == MUL_COEF_LO) begin
      tlo <= 34'((prod + 64'd536870912) >> 30);
    end
    if (cmd.cons && cmd.mul_sel == MUL_COEF_HI) begin
      if (cmd.term == T_LONG_FB2) begin
        lp <= fval;
      end else if (cmd.term == T_SHORT_FB2) begin
        sp <= fval;
      end
    end
    if (cmd.ring_rd) begin
      sig <= sig_next;
    end
    if (cmd.zchk) begin
      zflag <= stat.sum_zero;
      nrm   <= ssum;
      tsh   <= '0;
    end else if (cmd.norm_step && !stat.norm_done) begin
      nrm <= nrm << 2;
      tsh <= tsh + 5'd1;
    end
    if (cmd.div_load1) begin
      dvd <= nrm;
      rem <= '0;
    end else if (cmd.rdiv_step) begin
      rem <= 33'(rrem);
      dvd <= {dvd[47:0], rq};
    end else if (cmd.div_load2) begin
      dvd <= num + 64'(rr >> 1);
      dvs <= 33'(rr);
      rem <= '0;
    end else if (cmd.div_step) begin
      rem <= dge ? 33'(dtr - {1'b0, dvs}) : dtr[32:0];
      dvd <= {dvd[62:0], dge};
    end
    if (cmd.sqrt_load) begin
      sv   <= dvd;
      root <= '0;
      srem <= '0;
    end else if (cmd.sqrt_step) begin
      if (str >= trial) begin
        srem <= 33'(str - trial);
        root <= {root[30:0], 1'b1};
      end else begin
        srem <= str[32:0];
        root <= {root[30:0], 1'b0};
      end
      sv <= sv << 2;
    end
    if (cmd.fin) begin
      oscillator <= osc_next;
      rms_zero   <= zflag;
    end
  end

endmodule

### rtl/core/uosc_ctrl.sv
// uosc_ctrl: sequencer of the oscillator, issues datapath commands per step.
// Depends on uosc_pkg.
module uosc_ctrl import uosc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [14:0] {
    S_CLEAR = 15'b000000000000001,
    S_IDLE  = 15'b000000000000010,
    S_FILT  = 15'b000000000000100,
    S_RING  = 15'b000000000001000,
    S_SQO   = 15'b000000000010000,
    S_SQN   = 15'b000000000100000,
    S_SUM   = 15'b000000001000000,
    S_ZCHK  = 15'b000000010000000,
    S_NORM  = 15'b000000100000000,
    S_DIV1  = 15'b000001000000000,
    S_SQLD  = 15'b000010000000000,
    S_SQRT  = 15'b000100000000000,
    S_D2LD  = 15'b001000000000000,
    S_DIV2  = 15'b010000000000000,
    S_FIN   = 15'b100000000000000
  } state_t;

  localparam logic [CNT_W-1:0] FILT_LAST = CNT_W'(4 * NUM_REGS - 1);
  localparam logic [CNT_W-1:0] RDIV_LAST = CNT_W'(3);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(63);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(31);

  state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign in_stall = state != S_IDLE;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.ptr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = S_FILT;
        end
      end
      S_FILT: begin
        // per term: low half, then high half; each a multiply then a consume
        cmd.term    = term_t'(cnt[4:2]);
        cmd.mul_sel = cnt[1] ? MUL_COEF_HI : MUL_COEF_LO;
        cmd.mul     = !cnt[0];
        cmd.cons    = cnt[0];
        if (cnt == FILT_LAST) begin
          cnt_next   = '0;
          state_next = S_RING;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      S_RING: begin
        cmd.ring_rd = 1'b1;
        state_next  = S_SQO;
      end
      S_SQO: begin
        cmd.sq_old  = 1'b1;
        cmd.mul     = 1'b1;
        cmd.mul_sel = MUL_OLD;
        state_next  = S_SQN;
      end
      S_SQN: begin
        cmd.sq_new  = 1'b1;
        cmd.mul     = 1'b1;
        cmd.mul_sel = MUL_NEW;
        state_next  = S_SUM;
      end
      S_SUM: begin
        cmd.sum_add = 1'b1;
        state_next  = S_ZCHK;
      end
      S_ZCHK: begin
        cmd.zchk   = 1'b1;
        state_next = stat.sum_zero ? S_FIN : S_NORM;
      end
      S_NORM: begin
        cmd.norm_step = 1'b1;
        if (stat.norm_done) begin
          cmd.div_load1 = 1'b1;
          cnt_next      = '0;
          state_next    = S_DIV1;
        end
      end
      S_DIV1: begin
        // four 16-bit digits of the quotient by the window
        cmd.rdiv_step = 1'b1;
        if (cnt == RDIV_LAST) begin
          cnt_next   = '0;
          state_next = S_SQLD;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      S_SQLD: begin
        cmd.sqrt_load = 1'b1;
        state_next    = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt == SQRT_LAST) begin
          cnt_next   = '0;
          state_next = S_D2LD;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      S_D2LD: begin
        cmd.div_load2 = 1'b1;
        state_next    = S_DIV2;
      end
      S_DIV2: begin
        cmd.div_step = 1'b1;
        if (cnt == DIV_LAST) begin
          cnt_next   = '0;
          state_next = S_FIN;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (stat.out_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

### rtl/core/ultimate_oscillator_filter.sv
// Ultimate oscillator filter: two second-order high-pass filters on the price
// sample, their difference normalised by the RMS over the last RMS_WINDOW values.
// Depends on uosc_pkg, uosc_ctrl and uosc_dp.
//
// One request is worked on at a time. After acceptance the block forms the six
// filter products, each in a low and a high half on the single 32x32 multiplier,
// updates the ring and the sum of squares, normalises the sum of squares, divides
// it by the window (a reciprocal multiply per 16-bit digit), takes a bit-serial
// square root, runs a second bit-serial divide and writes the output register.
// When the sum of squares is zero it goes straight from that sum to the output
// register. The next request can be taken in the cycle after the result is
// written, and the result waits in the output register while that request is
// accepted; a stalled result holds the block at its output write until it is
// taken. After reset a clearing pass writes zero to each of the RMS_WINDOW
// entries of the signal ring before the first request.
module ultimate_oscillator_filter import uosc_pkg::*; #(
  parameter int RMS_WINDOW  = 100,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [REG_IDX_W-1:0]    cfg_index,
  input  logic [COEF_W-1:0]       cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [31:0]      sample,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OSC_W-1:0] oscillator,
  output logic                    rms_zero
);

  cmd_t  cmd;
  stat_t stat;

  uosc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  uosc_dp #(.RMS_WINDOW(RMS_WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample     (sample),
    .cmd        (cmd),
    .stat       (stat),
    .oscillator (oscillator),
    .rms_zero   (rms_zero),
    .out_valid  (out_valid),
    .out_stall  (out_stall)
  );

endmodule

### rtl/core/uosc_check.sv
// uosc_check: port-level checks of the ultimate oscillator filter, bound to it.
// Depends on uosc_pkg and ultimate_oscillator_filter.
module uosc_check import uosc_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [OSC_W-1:0] oscillator,
  input logic                    rms_zero
);

  // no result comes out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(oscillator) && $stable(rms_zero))
    else $error("stalled result changed");

  // zero rms forces a zero oscillator
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && rms_zero |-> oscillator == '0)
    else $error("nonzero oscillator with zero rms");

  // one request at a time: busy right after acceptance
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one in progress");

endmodule

bind ultimate_oscillator_filter uosc_check u_check (.*);
